[rtl/core/strict_decimal_to_int64_parser_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the strict decimal parser
// Concurrent check wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef STRICT_DECIMAL_TO_INT64_PARSER_MACROS_SVH
`define STRICT_DECIMAL_TO_INT64_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define SDI64_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SDI64_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SDI64_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SDI64_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/sdi64_pkg.sv]
// ----------------------------------------------------------------------------
// Strict decimal parser package
// Shared types and character constants of the int64 parser.
// ----------------------------------------------------------------------------
package sdi64_pkg;

   // Parse phase, one-hot
   typedef enum logic [5:0] {
      PH_LEAD   = 6'b000001,
      PH_SIGN   = 6'b000010,
      PH_DIGITS = 6'b000100,
      PH_TRAIL  = 6'b001000,
      PH_BAD    = 6'b010000,
      PH_WAIT   = 6'b100000
   } phase_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Both limits (2^63-1 and 2^63) share this quotient by ten
   localparam logic [63:0] MAG_LIMIT_DIV10 = 64'd922337203685477580;
   localparam logic [3:0]  POS_LAST_DIGIT  = 4'd7;
   localparam logic [3:0]  NEG_LAST_DIGIT  = 4'd8;

   // Parser state; nmag always holds the two's complement negation of mag
   typedef struct packed {
      phase_type   phase;
      logic        negative;
      logic [63:0] mag;
      logic [63:0] nmag;
   } state_type;

   typedef struct packed {
      logic [7:0]         status_byte;
      logic signed [63:0] value;
      logic               ok;
   } result_type;

   localparam int RSP_DATA_W = 80;
   localparam int REQ_DATA_W = 8;

endpackage

[rtl/core/sdi64_step.sv]
// ----------------------------------------------------------------------------
// Strict decimal parser step
// Next state and optional result for one byte of the string.
// ----------------------------------------------------------------------------
module sdi64_step (
   input  sdi64_pkg::state_type  st,
   input  logic [7:0]            ch,
   input  logic                  last,
   output sdi64_pkg::state_type  st_next,
   output logic                  emit,
   output sdi64_pkg::result_type result
);

   logic                 is_blank;
   logic                 is_digit;
   logic [3:0]           digit;
   logic [3:0]           last_digit;
   logic                 ovf;
   logic [63:0]          mag10;
   logic [63:0]          nmag10;
   sdi64_pkg::state_type added;
   sdi64_pkg::state_type taken;
   sdi64_pkg::state_type cleared;
   sdi64_pkg::state_type src;
   logic                 ok;

   assign is_blank = ((ch >= sdi64_pkg::CH_TAB) && (ch <= sdi64_pkg::CH_CR)) ||
                     (ch == sdi64_pkg::CH_SPACE);
   assign is_digit = (ch >= sdi64_pkg::CH_ZERO) && (ch <= sdi64_pkg::CH_NINE);
   assign digit    = ch[3:0];

   // Range check before the multiply-add, so the magnitude never wraps
   assign last_digit = st.negative ? sdi64_pkg::NEG_LAST_DIGIT : sdi64_pkg::POS_LAST_DIGIT;
   assign ovf = (st.mag > sdi64_pkg::MAG_LIMIT_DIV10) ||
                ((st.mag == sdi64_pkg::MAG_LIMIT_DIV10) && (digit > last_digit));

   assign mag10  = (st.mag << 3) + (st.mag << 1) + {60'd0, digit};
   assign nmag10 = (st.nmag << 3) + (st.nmag << 1) - {60'd0, digit};

   always_comb begin
      added = st;
      if (ovf) begin
         added.phase = sdi64_pkg::PH_BAD;
      end else begin
         added.phase = sdi64_pkg::PH_DIGITS;
         added.mag   = mag10;
         added.nmag  = nmag10;
      end
   end

   assign cleared = '{phase: sdi64_pkg::PH_LEAD, negative: 1'b0, mag: 64'd0, nmag: 64'd0};

   // Consume one nonzero byte
   always_comb begin
      taken = st;
      unique case (st.phase)
         sdi64_pkg::PH_LEAD: begin
            if (is_blank) begin
               taken = st;
            end else if ((ch == sdi64_pkg::CH_MINUS) || (ch == sdi64_pkg::CH_PLUS)) begin
               taken.negative = (ch == sdi64_pkg::CH_MINUS);
               taken.phase    = sdi64_pkg::PH_SIGN;
            end else if (is_digit) begin
               taken = added;
            end else begin
               taken.phase = sdi64_pkg::PH_BAD;
            end
         end
         sdi64_pkg::PH_SIGN: begin
            if (is_digit) begin
               taken = added;
            end else begin
               taken.phase = sdi64_pkg::PH_BAD;
            end
         end
         sdi64_pkg::PH_DIGITS: begin
            if (is_digit) begin
               taken = added;
            end else if (is_blank) begin
               taken.phase = sdi64_pkg::PH_TRAIL;
            end else begin
               taken.phase = sdi64_pkg::PH_BAD;
            end
         end
         sdi64_pkg::PH_TRAIL: begin
            if (!is_blank) begin
               taken.phase = sdi64_pkg::PH_BAD;
            end
         end
         default: begin
            taken.phase = sdi64_pkg::PH_BAD;
         end
      endcase
   end

   // Framing: wait-for-last, string terminator, last byte
   always_comb begin
      st_next = st;
      emit    = 1'b0;
      src     = st;
      if (st.phase == sdi64_pkg::PH_WAIT) begin
         if (last) begin
            st_next = cleared;
         end
      end else if (ch == sdi64_pkg::CH_NUL) begin
         emit = 1'b1;
         if (last) begin
            st_next = cleared;
         end else begin
            st_next.phase = sdi64_pkg::PH_WAIT;
         end
      end else begin
         src = taken;
         if (last) begin
            emit    = 1'b1;
            st_next = cleared;
         end else begin
            st_next = taken;
         end
      end
   end

   assign ok = (src.phase == sdi64_pkg::PH_DIGITS) || (src.phase == sdi64_pkg::PH_TRAIL);

   always_comb begin
      result.ok          = ok;
      result.value       = ok ? (src.negative ? src.nmag : src.mag) : 64'sd0;
      result.status_byte = result.value[7:0];
   end

endmodule

[rtl/core/strict_decimal_to_int64_parser.sv]
// ----------------------------------------------------------------------------
// Strict decimal string to int64 parser
// Streams a text string one byte per transfer and reports one result per
// string: validity, the signed 64-bit value and its low byte as exit code.
// ----------------------------------------------------------------------------
// Usage: send the string one byte per req transfer, with req_tlast on its
// final byte. Leading white space (bytes 9-13 and 32), an optional sign,
// one or more digits and trailing white space make a valid string; the value
// must fit in a signed 64-bit integer, otherwise ok is 0 and value is 0. A
// zero byte ends the string at once and yields the result; bytes after it are
// dropped without a result up to and including the one marked last. The
// block takes one byte per cycle unless a held result is not taken: a
// byte is held in the input register, then one pass through the step logic
// (the 64-bit range compares and the multiply-by-ten add) updates the state
// and loads the result register, which holds the result until it transfers.
// The input register keeps accepting while a result waits in the result
// register, and stalls only once both hold an item and rsp_tready is low.
// ----------------------------------------------------------------------------
`include "strict_decimal_to_int64_parser_macros.svh"

module strict_decimal_to_int64_parser (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sdi64_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] ch
   input  logic                             req_tlast,   // last

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sdi64_pkg::RSP_DATA_W-1:0] rsp_tdata    // [0] ok, [64:1] value,
                                                         // [72:65] status_byte, rest 0
);

   // Input register
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [7:0]           in_ch_ff;
   logic                 in_last_ff;

   // Parser state
   sdi64_pkg::state_type st_ff;
   sdi64_pkg::state_type st_in;

   // Result register
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   sdi64_pkg::result_type  rsp_data_ff;

   logic                   req_xfer;
   logic                   advance;
   logic                   step_emit;
   sdi64_pkg::state_type   step_next;
   sdi64_pkg::result_type  step_result;

   assign req_xfer = req_tvalid && req_tready;

   // Move the held byte through the step logic when the result slot is free
   // or is being emptied in this cycle
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   sdi64_step u_step (
      .st      (st_ff),
      .ch      (in_ch_ff),
      .last    (in_last_ff),
      .st_next (step_next),
      .emit    (step_emit),
      .result  (step_result)
   );

   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   assign st_in = advance ? step_next : st_ff;

   // A byte that ends no string still frees the result slot if it drains
   always_comb begin
      if (advance) begin
         rsp_valid_in = step_emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '{phase: sdi64_pkg::PH_LEAD, negative: 1'b0,
                           mag: 64'd0, nmag: 64'd0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
      end
   end

   // Payload: hold the byte until it is used, hold the result until taken
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ch_ff   <= req_tdata[7:0];
         in_last_ff <= req_tlast;
      end
      if (advance && step_emit) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

   // The negated copy of the magnitude must track it at all times
   `SDI64_ASSERT_SAME(a_nmag_tracks_mag, clock, reset, 1'b1,
                      (st_ff.mag + st_ff.nmag) == 64'd0,
                      "negated magnitude out of step")

   // A held byte that cannot advance stays in the input register
   `SDI64_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance,
                      in_valid_ff && (in_ch_ff == $past(in_ch_ff)),
                      "input byte lost while stalled")

   // An invalid result carries zero in value and exit code
   `SDI64_ASSERT_SAME(a_bad_is_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.ok,
                      (rsp_data_ff.value == 64'sd0) && (rsp_data_ff.status_byte == 8'd0),
                      "invalid result with nonzero value")

endmodule
